// ===== sv/sle_pkg.sv =====
// Shared types and codes for the sorted list engine.
// No dependencies; every other source file in the project imports this package.
package sle_pkg;

  // Request actions.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;
  localparam logic [1:0] ACT_GET    = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
    logic [3:0]         index;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] data_out;
    logic [4:0]         count;
  } result_t;

  // Per-request enables broadcast to every cell of the row.
  typedef struct packed {
    logic insert_en;
    logic remove_en;
  } cell_ctl_t;

endpackage

// ===== sv/sle_cell.sv =====
// One storage cell of the sorted list row.
// Depends on sle_pkg for the broadcast control struct.
module sle_cell #(
  parameter int VALUE_BITS = 32,
  parameter int POS        = 0
) (
  input  logic                         clk,
  input  sle_pkg::cell_ctl_t           ctl,
  input  logic                         valid,
  input  logic signed [VALUE_BITS-1:0] vin,
  input  logic [3:0]                   index,
  input  logic                         lt_left,
  input  logic signed [VALUE_BITS-1:0] entry_left,
  input  logic signed [VALUE_BITS-1:0] entry_right,
  output logic                         lt,
  output logic                         eq,
  output logic                         hit,
  output logic signed [VALUE_BITS-1:0] entry,
  output logic signed [VALUE_BITS-1:0] rd_data
);
  import sle_pkg::*;

  logic signed [VALUE_BITS-1:0] entry_next;

  assign lt  = valid && (entry < vin);
  assign eq  = valid && (entry == vin);
  assign hit = valid && (int'(index) == POS);
  assign rd_data = hit ? entry : '0;

  // The row is sorted, so lt is high on a prefix of the cells. An insert
  // lands where the prefix ends and everything past it moves one cell up;
  // a remove pulls everything from that point one cell down.
  always_comb begin
    entry_next = entry;
    if (ctl.insert_en) begin
      if (!lt_left) begin
        entry_next = entry_left;
      end else if (!lt) begin
        entry_next = vin;
      end
    end else if (ctl.remove_en) begin
      if (!lt) begin
        entry_next = entry_right;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== sv/sorted_list_engine_top.sv =====
// Top level of the sorted list engine: a row of sle_cell instances plus
// the fill counter and the result register. Depends on sle_pkg and sle_cell.
//
//   Channel   Signals              Direction  Transfer condition
//   request   start, busy, req     in         start high and busy low at clk rise
//   result    done, result         out        done high for one cycle, never held
//
// Each request is handled at once: all cells compare the value against their
// entry and shift toward or away from their neighbor in the same clock edge,
// so a new request may follow in the very next cycle. The result appears in
// the cycle after the request's transfer. Reset is synchronous and clears
// only the fill count and the strobe; cell contents stay undefined until an
// insert writes them. busy is high only while reset is asserted, and the
// receiver cannot stall the result channel.
module sorted_list_engine_top #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sle_pkg::req_t     req,
  output logic              busy,
  output logic              done,
  output sle_pkg::result_t  result
);
  import sle_pkg::*;

  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [FILL_W-1:0]            fill;
  logic [FILL_W-1:0]            fill_next;
  logic                         accept;
  logic                         full;
  logic                         found_any;
  logic                         get_hit;
  logic signed [VALUE_BITS-1:0] vin;
  logic signed [VALUE_BITS-1:0] rd_value;
  cell_ctl_t                    ctl;
  result_t                      result_next;

  logic [DEPTH-1:0]             valid_v;
  logic [DEPTH-1:0]             lt_v;
  logic [DEPTH-1:0]             eq_v;
  logic [DEPTH-1:0]             hit_v;
  logic [DEPTH-1:0]             lt_left_v;
  logic signed [VALUE_BITS-1:0] entry_q     [DEPTH];
  logic signed [VALUE_BITS-1:0] entry_left  [DEPTH];
  logic signed [VALUE_BITS-1:0] entry_right [DEPTH];
  logic signed [VALUE_BITS-1:0] rd_q        [DEPTH];

  // A request is taken whenever the block is out of reset.
  assign busy   = rst;
  assign accept = start && !busy;

  // Only the low VALUE_BITS bits of the operand count, read as signed.
  assign vin  = VALUE_BITS'(req.value);
  assign full = (fill == FILL_W'(DEPTH));

  // Neighbor wiring. The first cell sees an always-smaller left neighbor so
  // that an insert below every entry lands in it; the last cell's right
  // neighbor is itself, which only matters for a slot that becomes empty.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_v[i] = (int'(fill) > i);
      if (i == 0) begin
        lt_left_v[i]  = 1'b1;
        entry_left[i] = vin;
      end else begin
        lt_left_v[i]  = lt_v[i-1];
        entry_left[i] = entry_q[i-1];
      end
      if (i == DEPTH - 1) begin
        entry_right[i] = entry_q[i];
      end else begin
        entry_right[i] = entry_q[i+1];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      sle_cell #(
        .VALUE_BITS (VALUE_BITS),
        .POS        (g)
      ) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .valid       (valid_v[g]),
        .vin         (vin),
        .index       (req.index),
        .lt_left     (lt_left_v[g]),
        .entry_left  (entry_left[g]),
        .entry_right (entry_right[g]),
        .lt          (lt_v[g]),
        .eq          (eq_v[g]),
        .hit         (hit_v[g]),
        .entry       (entry_q[g]),
        .rd_data     (rd_q[g])
      );
    end
  endgenerate

  // At most one cell matches the get index, so the read is an OR of the
  // gated cell outputs.
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_value = rd_value | rd_q[i];
    end
  end

  assign found_any = |eq_v;
  assign get_hit   = |hit_v;

  assign ctl.insert_en = accept && (req.action == ACT_INSERT) && !full;
  assign ctl.remove_en = accept && (req.action == ACT_REMOVE) && found_any;

  always_comb begin
    fill_next = fill;
    if (ctl.insert_en) begin
      fill_next = fill + FILL_W'(1);
    end else if (ctl.remove_en) begin
      fill_next = fill - FILL_W'(1);
    end
  end

  // Result fields for the request being transferred this cycle.
  always_comb begin
    result_next          = '0;
    result_next.count    = 5'(fill_next);
    unique case (req.action)
      ACT_INSERT: begin
        if (full) begin
          result_next.status = ST_FULL;
        end
      end
      ACT_REMOVE: begin
        if (!found_any) begin
          result_next.status = ST_NOT_FOUND;
        end
      end
      ACT_SEARCH: begin
        result_next.found = found_any;
      end
      ACT_GET: begin
        if (get_hit) begin
          result_next.data_out = 32'(rd_value);
        end else begin
          result_next.status = ST_BAD_INDEX;
        end
      end
      default: begin
        result_next.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      done <= 1'b0;
    end else begin
      fill <= fill_next;
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  // Every transferred request yields exactly one result in the next cycle.
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("request transfer without a result strobe");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("result strobe without a request transfer");

  // The reported count is the fill that the action left behind.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.count == 5'(fill)))
    else $error("result count differs from fill");

  // A successful insert grows the list by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.insert_en |=> (fill == $past(fill) + FILL_W'(1)))
    else $error("insert did not advance fill");

  // A full status is only reported when the list held DEPTH entries.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_FULL)) |-> (fill == FILL_W'(DEPTH)))
    else $error("full status with room left");

endmodule

// ===== test/sorted_list_engine_top_tb.sv =====
// Self-checking testbench for sorted_list_engine_top: random and directed requests
// are checked against a behavioral sorted-list predictor kept in a scoreboard class.
// Depends on sle_pkg and the sorted_list_engine_top RTL.
`timescale 1ns / 100ps

module sorted_list_engine_top_tb;
  import sle_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT  = 200000;

  class sorted_list_scoreboard;
    logic signed [31:0] entries [DEPTH];
    int unsigned        fill;
    result_t            expected_q [$];
    int unsigned        errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // Prints one line per mismatch and counts every one.
    task report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Applies an accepted request to the shadow list and queues its result.
    function void note_request(input req_t r);
      result_t            res;
      logic signed [31:0] v;
      int                 i;
      int                 k;
      res = '0;
      v   = $signed(r.value);
      case (r.action)
        ACT_INSERT: begin
          if (fill >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            // New value goes in front of any equal entries.
            i = fill;
            while (i > 0 && entries[i-1] >= v) begin
              entries[i] = entries[i-1];
              i--;
            end
            entries[i] = v;
            fill++;
          end
        end
        ACT_REMOVE: begin
          k = fill;
          for (i = fill - 1; i >= 0; i--)
            if (entries[i] == v) k = i;
          if (k >= fill) begin
            res.status = ST_NOT_FOUND;
          end else begin
            for (i = k; i + 1 < fill; i++)
              entries[i] = entries[i+1];
            fill--;
          end
        end
        ACT_SEARCH: begin
          for (i = 0; i < fill; i++)
            if (entries[i] == v) res.found = 1'b1;
        end
        default: begin
          if (r.index < fill) res.data_out = entries[r.index];
          else                res.status   = ST_BAD_INDEX;
        end
      endcase
      res.count = 5'(fill);
      expected_q.push_back(res);
    endfunction

    task check_result(input result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.found !== want.found)
          report_mismatch($sformatf("found got %0b want %0b", got.found, want.found));
        if (got.data_out !== want.data_out)
          report_mismatch($sformatf("data_out got %0d want %0d",
                                    got.data_out, want.data_out));
        if (got.count !== want.count)
          report_mismatch($sformatf("count got %0d want %0d", got.count, want.count));
      end
    endtask
  endclass

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  req_t    req   = '0;
  logic    busy;
  logic    done;
  result_t result;

  sorted_list_scoreboard sb = new();
  int unsigned           cycles = 0;

  sorted_list_engine_top #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (32)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Watchdog: a healthy run finishes far below this bound, even with the
  // longest idle gap drawn for every request.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sorted_list_engine_top verification failed");
      $finish;
    end
  end

  // Monitor. Inputs change only through nonblocking assignments at the
  // clock edge, so the values read here are the ones the DUT sampled.
  // A request transfer feeds the predictor; every result strobe is checked
  // against the oldest queued expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_request(req);
      if (done === 1'b1)       sb.check_result(result);
      else if (done !== 1'b0)  sb.report_mismatch("result strobe is unknown");
    end
  end

  function automatic req_t make_req(input logic [1:0] act, input logic signed [31:0] v,
                                    input logic [3:0] idx);
    req_t r;
    r.action = act;
    r.value  = v;
    r.index  = idx;
    return r;
  endfunction

  // Idles for the given number of cycles, then presents the request and
  // holds it until the transfer happens. Back-to-back requests keep start
  // high, so start is never lowered and raised in the same time step.
  task automatic send_request(input req_t r, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  // Random operand: often a value already held, so removes and searches hit,
  // plus a narrow band that breeds duplicates and fully random words.
  function automatic logic signed [31:0] pick_value();
    int c;
    c = $urandom_range(9);
    if (c < 4 && sb.fill > 0) return sb.entries[$urandom_range(sb.fill - 1)];
    if (c < 7)                return $signed(32'($urandom_range(8))) - 4;
    return $signed($urandom);
  endfunction

  initial begin
    logic               grow;
    logic               burst;
    int                 w;
    int                 n;
    logic [1:0]         act;
    logic [3:0]         idx;

    // Synchronous reset held from the start, released once.
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty-list corner cases first.
    send_request(make_req(ACT_GET,    32'sd0, 4'd0), 0);   // bad index on empty
    send_request(make_req(ACT_REMOVE, 32'sd5, 4'd0), 1);   // absent value
    send_request(make_req(ACT_SEARCH, 32'sh8000_0000, 4'd0), 0);
    // Extremes and a duplicate, which must land in front of its twin.
    send_request(make_req(ACT_INSERT, 32'sh7FFF_FFFF, 4'd0), 0);
    send_request(make_req(ACT_INSERT, 32'sh8000_0000, 4'd0), 0);
    send_request(make_req(ACT_INSERT, 32'sd0, 4'd0), 2);
    send_request(make_req(ACT_INSERT, -32'sd1, 4'd0), 0);
    send_request(make_req(ACT_INSERT, 32'sd0, 4'd0), 0);
    send_request(make_req(ACT_SEARCH, 32'sh8000_0000, 4'd0), 0);
    send_request(make_req(ACT_GET,    32'sd0, 4'd0), 0);
    send_request(make_req(ACT_GET,    32'sd0, 4'd4), 3);
    send_request(make_req(ACT_GET,    32'sd0, 4'd15), 0);  // beyond fill
    send_request(make_req(ACT_REMOVE, 32'sd0, 4'd0), 0);   // one of two equal entries
    // Fill to capacity, then overflow, read the last slot and trim the top.
    for (int i = 0; i < 12; i++)
      send_request(make_req(ACT_INSERT, $signed(32'(i * 1000 - 5000)), 4'd0), 0);
    send_request(make_req(ACT_INSERT, 32'sd42, 4'd0), 0);  // list full, dropped
    send_request(make_req(ACT_GET,    32'sd0, 4'd15), 1);
    send_request(make_req(ACT_REMOVE, 32'sh7FFF_FFFF, 4'd0), 0);

    // Random part. Grow and shrink phases alternate so the list swings
    // between empty and full; every 50 requests the driver draws anew whether it
    // sends back-to-back bursts or uses random idle gaps.
    grow  = 1'b1;
    burst = 1'b0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) burst = ($urandom_range(2) == 0);
      if (grow && sb.fill == DEPTH && $urandom_range(3) == 0) grow = 1'b0;
      if (!grow && sb.fill == 0 && $urandom_range(3) == 0)    grow = 1'b1;
      w = $urandom_range(99);
      if (grow)
        act = (w < 50) ? ACT_INSERT : (w < 65) ? ACT_REMOVE :
              (w < 80) ? ACT_SEARCH : ACT_GET;
      else
        act = (w < 15) ? ACT_INSERT : (w < 55) ? ACT_REMOVE :
              (w < 75) ? ACT_SEARCH : ACT_GET;
      if (sb.fill > 0 && $urandom_range(9) < 6) idx = 4'($urandom_range(sb.fill - 1));
      else                                      idx = 4'($urandom_range(15));
      send_request(make_req(act, pick_value(), idx), burst ? 0 : $urandom_range(9));
    end
    start <= 1'b0;

    // Drain: the last result shows up in the cycle after its transfer.
    for (n = 0; n < 20 && sb.expected_q.size() != 0; n++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));

    if (sb.errors == 0) begin
      $display("sorted_list_engine_top verification clean");
    end else begin
      $display("sorted_list_engine_top verification failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/sle_pkg.sv
sv/sle_cell.sv
sv/sorted_list_engine_top.sv
test/sorted_list_engine_top_tb.sv
